// ----- design/polygon_line_split_area_balance_macros.svh -----
// Assertion helpers shared by the design files.
`ifndef POLYGON_LINE_SPLIT_AREA_BALANCE_MACROS_SVH
`define POLYGON_LINE_SPLIT_AREA_BALANCE_MACROS_SVH

// same-cycle implication
`define PLSAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PLSAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/plsab_pkg.sv -----
package plsab_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int MAX_VERTICES = 16;

	localparam int COORD_W = 8;
	localparam int PT_W    = COORD_W + FRAC_BITS;
	localparam int PROD_W  = 2 * PT_W;
	localparam int SUM_W   = PROD_W + 12;
	localparam int TOT_W   = SUM_W + 1;
	localparam int CNT_W   = $clog2(MAX_VERTICES + 2);
	localparam int MP_W    = 18;
	localparam int NUM_W   = 19;
	localparam int DEN_W   = 18;
	localparam int BLEND_W = 26;
	localparam int DVD_W   = (BLEND_W + FRAC_BITS > 48) ? BLEND_W + FRAC_BITS : 48;
	localparam int DSR_W   = 32;
	localparam int DEV_W   = 14;

	localparam logic [DEV_W-1:0] DEV_MAX  = DEV_W'(12800);
	localparam logic [14:0]      PCT_FULL = 15'd25600;

	typedef enum logic [5:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_LATCH,
		OP_SAT,
		OP_CLASS,
		OP_TGT_CUR,
		OP_TGT_FIRST,
		OP_EMUL,
		OP_EDIFF,
		OP_ENORM,
		OP_BMUL_X,
		OP_BDIV_X,
		OP_ISX,
		OP_BMUL_Y,
		OP_BDIV_Y,
		OP_ISY,
		OP_PT_IS0,
		OP_PT_IS1,
		OP_PT_CUR,
		OP_PT_CL0,
		OP_PT_CL1,
		OP_PMUL,
		OP_PDIF,
		OP_PACC,
		OP_ADV,
		OP_ABS,
		OP_TOT,
		OP_SHIFT,
		OP_PCTMUL,
		OP_PCTDIV,
		OP_RES_PCT,
		OP_RES_DEG,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_lt_max;
		logic cnt_valid;
		logic cside_ne;
		logic fside_ne;
		logic last;
		logic t_big;
		logic t_zero;
		logic div_busy;
	} stat_t;

	// 1 = above the line; vertical or coincident line uses x < x1
	function automatic logic side_of(input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
		input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2,
		input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy);
		logic signed [COORD_W:0]   dx;
		logic signed [COORD_W:0]   dy;
		logic signed [COORD_W:0]   rx;
		logic signed [COORD_W:0]   ry;
		logic signed [NUM_W-1:0]   c;
		logic                      s;
		dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
		dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
		rx = $signed({1'b0, vx}) - $signed({1'b0, x1});
		ry = $signed({1'b0, vy}) - $signed({1'b0, y1});
		c  = NUM_W'(dy) * NUM_W'(rx) - NUM_W'(ry) * NUM_W'(dx);
		if (dx == '0) begin
			s = (vx < x1);
		end else if (!dx[COORD_W]) begin
			s = (c > 0);
		end else begin
			s = (c < 0);
		end
		return s;
	endfunction

endpackage

// ----- design/plsab_div.sv -----
module plsab_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plsab_pkg::DVD_W-1:0] dividend,
	input  logic [plsab_pkg::DSR_W-1:0] divisor,
	output logic                        busy,
	output logic [plsab_pkg::DVD_W-1:0] quotient
);
	import plsab_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DSR_W:0]    trial;
	logic              qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;
endmodule

// ----- design/plsab_dp.sv -----
`include "polygon_line_split_area_balance_macros.svh"

module plsab_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plsab_pkg::cmd_t               cmd,
	output plsab_pkg::stat_t              stat,
	input  logic [plsab_pkg::COORD_W-1:0] line_start_x,
	input  logic [plsab_pkg::COORD_W-1:0] line_start_y,
	input  logic [plsab_pkg::COORD_W-1:0] line_end_x,
	input  logic [plsab_pkg::COORD_W-1:0] line_end_y,
	input  logic [plsab_pkg::COORD_W-1:0] vertex_x,
	input  logic [plsab_pkg::COORD_W-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic [plsab_pkg::DEV_W-1:0]   split_deviation,
	output logic                          degenerate
);
	import plsab_pkg::*;

	logic [COORD_W-1:0] in_x1_q, in_y1_q, in_x2_q, in_y2_q;
	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic               last_q;
	logic [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [COORD_W-1:0] first_x_q, first_y_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic               pside_q, cside_q, fside_q;
	logic [CNT_W-1:0]   count_q;

	logic signed [MP_W-1:0]  m1_q, m2_q, m3_q, m4_q;
	logic signed [NUM_W-1:0] num_q, den_q;
	logic [DEN_W-1:0]        nnum_q, nden_q;
	logic [BLEND_W-1:0]      bp1_q, bp2_q;
	logic [PT_W-1:0]         ix_q, iy_q;

	logic [PT_W-1:0]          ptx_q, pty_q;
	logic                     ptk_q;
	logic [PROD_W-1:0]        p1_q, p2_q;
	logic signed [PROD_W:0]   d_q;
	logic [PT_W-1:0]          fx_q [2];
	logic [PT_W-1:0]          fy_q [2];
	logic [PT_W-1:0]          lx_q [2];
	logic [PT_W-1:0]          ly_q [2];
	logic [1:0]               has_q;
	logic signed [SUM_W-1:0]  sum_q [2];

	logic [SUM_W-1:0]  a0_q, a1_q;
	logic [TOT_W-1:0]  t_q, m_q;
	logic [DVD_W-1:0]  pm_q;
	logic [DEV_W-1:0]  res_dev_q;
	logic              res_deg_q;
	logic [DEV_W-1:0]  out_dev_q;
	logic              out_deg_q;

	logic signed [COORD_W:0] dxl, dyl, dye, rx, ry, ex, ey;
	logic signed [NUM_W-1:0] n1, d1;
	logic [DEN_W-1:0]        nn, dn;
	logic [BLEND_W-1:0]      bsum;
	logic                    div_start, div_busy;
	logic [DVD_W-1:0]        div_dvd, quot;
	logic [DSR_W-1:0]        div_dsr;
	logic [SUM_W-1:0]        abs0, abs1;
	logic [PT_W-1:0]         cur_px, cur_py;

	assign cur_px = {cur_x_q, {FRAC_BITS{1'b0}}};
	assign cur_py = {cur_y_q, {FRAC_BITS{1'b0}}};

	// edge P=prev, C=target against latched line
	always_comb begin
		dxl = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
		dyl = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
		dye = (dxl == '0) ? (COORD_W+1)'(1) : dyl;
		rx  = $signed({1'b0, x1_q}) - $signed({1'b0, prev_x_q});
		ry  = $signed({1'b0, y1_q}) - $signed({1'b0, prev_y_q});
		ex  = $signed({1'b0, tx_q}) - $signed({1'b0, prev_x_q});
		ey  = $signed({1'b0, ty_q}) - $signed({1'b0, prev_y_q});
	end

	always_comb begin
		if (den_q < 0) begin
			n1 = -num_q;
			d1 = -den_q;
		end else begin
			n1 = num_q;
			d1 = den_q;
		end
		if (d1 == '0) begin
			dn = DEN_W'(1);
			nn = '0;
		end else begin
			dn = DEN_W'(d1);
			if (n1 < 0) begin
				nn = '0;
			end else if (n1 > d1) begin
				nn = DEN_W'(d1);
			end else begin
				nn = DEN_W'(n1);
			end
		end
	end

	assign bsum = bp1_q + bp2_q;
	assign abs0 = sum_q[0][SUM_W-1] ? SUM_W'(-sum_q[0]) : SUM_W'(sum_q[0]);
	assign abs1 = sum_q[1][SUM_W-1] ? SUM_W'(-sum_q[1]) : SUM_W'(sum_q[1]);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'({bsum, {FRAC_BITS{1'b0}}}) + DVD_W'(nden_q >> 1);
		div_dsr   = DSR_W'(nden_q);
		unique case (cmd.op)
			OP_BDIV_X, OP_BDIV_Y: begin
				div_start = 1'b1;
			end
			OP_PCTDIV: begin
				div_start = 1'b1;
				div_dvd   = pm_q + DVD_W'(t_q[DSR_W-1:1]);
				div_dsr   = t_q[DSR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	plsab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			has_q    <= '0;
			pside_q  <= 1'b0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
		end else begin
			unique case (cmd.op)
				OP_SAT: begin
					count_q <= CNT_W'(MAX_VERTICES + 1);
				end
				OP_ADV: begin
					count_q <= count_q + 1'b1;
					pside_q <= cside_q;
				end
				OP_PACC: begin
					if (has_q[ptk_q]) begin
						sum_q[ptk_q] <= sum_q[ptk_q] + SUM_W'(d_q);
					end
					has_q[ptk_q] <= 1'b1;
				end
				OP_EMIT: begin
					count_q  <= '0;
					has_q    <= '0;
					pside_q  <= 1'b0;
					sum_q[0] <= '0;
					sum_q[1] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				in_x1_q <= line_start_x;
				in_y1_q <= line_start_y;
				in_x2_q <= line_end_x;
				in_y2_q <= line_end_y;
				cur_x_q <= vertex_x;
				cur_y_q <= vertex_y;
				last_q  <= last_vertex;
			end
			OP_LATCH: begin
				x1_q      <= in_x1_q;
				y1_q      <= in_y1_q;
				x2_q      <= in_x2_q;
				y2_q      <= in_y2_q;
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
			end
			OP_CLASS: begin
				cside_q <= side_of(x1_q, y1_q, x2_q, y2_q, cur_x_q, cur_y_q);
				fside_q <= side_of(x1_q, y1_q, x2_q, y2_q, first_x_q, first_y_q);
			end
			OP_TGT_CUR: begin
				tx_q <= cur_x_q;
				ty_q <= cur_y_q;
			end
			OP_TGT_FIRST: begin
				tx_q <= first_x_q;
				ty_q <= first_y_q;
			end
			OP_EMUL: begin
				m1_q <= MP_W'(rx) * MP_W'(dye);
				m2_q <= MP_W'(ry) * MP_W'(dxl);
				m3_q <= MP_W'(ex) * MP_W'(dye);
				m4_q <= MP_W'(ey) * MP_W'(dxl);
			end
			OP_EDIFF: begin
				num_q <= NUM_W'(m1_q) - NUM_W'(m2_q);
				den_q <= NUM_W'(m3_q) - NUM_W'(m4_q);
			end
			OP_ENORM: begin
				nnum_q <= nn;
				nden_q <= dn;
			end
			OP_BMUL_X: begin
				bp1_q <= BLEND_W'(prev_x_q) * BLEND_W'(nden_q - nnum_q);
				bp2_q <= BLEND_W'(tx_q) * BLEND_W'(nnum_q);
			end
			OP_BMUL_Y: begin
				bp1_q <= BLEND_W'(prev_y_q) * BLEND_W'(nden_q - nnum_q);
				bp2_q <= BLEND_W'(ty_q) * BLEND_W'(nnum_q);
			end
			OP_ISX: begin
				ix_q <= quot[PT_W-1:0];
			end
			OP_ISY: begin
				iy_q <= quot[PT_W-1:0];
			end
			OP_PT_IS0, OP_PT_IS1: begin
				ptx_q <= ix_q;
				pty_q <= iy_q;
				ptk_q <= (cmd.op == OP_PT_IS1);
			end
			OP_PT_CUR: begin
				ptx_q <= cur_px;
				pty_q <= cur_py;
				ptk_q <= cside_q;
			end
			OP_PT_CL0: begin
				ptx_q <= fx_q[0];
				pty_q <= fy_q[0];
				ptk_q <= 1'b0;
			end
			OP_PT_CL1: begin
				ptx_q <= fx_q[1];
				pty_q <= fy_q[1];
				ptk_q <= 1'b1;
			end
			OP_PMUL: begin
				p1_q <= PROD_W'(lx_q[ptk_q]) * PROD_W'(pty_q);
				p2_q <= PROD_W'(ly_q[ptk_q]) * PROD_W'(ptx_q);
			end
			OP_PDIF: begin
				d_q <= $signed({1'b0, p1_q}) - $signed({1'b0, p2_q});
			end
			OP_PACC: begin
				if (!has_q[ptk_q]) begin
					fx_q[ptk_q] <= ptx_q;
					fy_q[ptk_q] <= pty_q;
				end
				lx_q[ptk_q] <= ptx_q;
				ly_q[ptk_q] <= pty_q;
			end
			OP_ADV: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			OP_ABS: begin
				a0_q <= abs0;
				a1_q <= abs1;
			end
			OP_TOT: begin
				t_q <= TOT_W'(a0_q) + TOT_W'(a1_q);
				m_q <= (a0_q < a1_q) ? TOT_W'(a0_q) : TOT_W'(a1_q);
			end
			OP_SHIFT: begin
				t_q <= t_q >> 1;
				m_q <= m_q >> 1;
			end
			OP_PCTMUL: begin
				pm_q <= DVD_W'(m_q[DSR_W-1:0]) * DVD_W'(PCT_FULL);
			end
			OP_RES_PCT: begin
				res_dev_q <= (quot > DVD_W'(DEV_MAX)) ? '0 : DEV_MAX - quot[DEV_W-1:0];
				res_deg_q <= 1'b0;
			end
			OP_RES_DEG: begin
				res_dev_q <= '0;
				res_deg_q <= 1'b1;
			end
			OP_EMIT: begin
				out_dev_q <= res_dev_q;
				out_deg_q <= res_deg_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.cnt_zero   = (count_q == '0);
		stat.cnt_lt_max = (count_q < CNT_W'(MAX_VERTICES));
		stat.cnt_valid  = (count_q >= CNT_W'(3)) && (count_q <= CNT_W'(MAX_VERTICES));
		stat.cside_ne   = (cside_q != pside_q);
		stat.fside_ne   = (fside_q != pside_q);
		stat.last       = last_q;
		stat.t_big      = |t_q[TOT_W-1:DSR_W];
		stat.t_zero     = (t_q == '0);
		stat.div_busy   = div_busy;
	end

	assign split_deviation = out_dev_q;
	assign degenerate      = out_deg_q;

	`PLSAB_ASSERT_IMP(a_div_idle_start, clk, arst_n, div_start, !div_busy)
	`PLSAB_ASSERT_IMP(a_cnt_range, clk, arst_n, cmd.op == OP_ADV,
		count_q < CNT_W'(MAX_VERTICES))
	`PLSAB_ASSERT_NEXT(a_emit_clears, clk, arst_n, cmd.op == OP_EMIT,
		count_q == '0 && has_q == '0)
endmodule

// ----- design/plsab_ctrl.sv -----
`include "polygon_line_split_area_balance_macros.svh"

module plsab_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	output logic             vtx_stall,
	output logic             res_valid,
	input  logic             res_stall,
	input  plsab_pkg::stat_t stat,
	output plsab_pkg::cmd_t  cmd
);
	import plsab_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_CLASS, S_BRANCH,
		S_E1, S_E2, S_E3, S_BX, S_DX, S_WX, S_BY, S_DY, S_WY,
		S_PSEL, S_PMUL, S_PDIF, S_PACC, S_ADV, S_CHKLAST,
		S_ABS, S_TOT, S_NORM, S_PCTM, S_PCTD, S_PCTW, S_RES
	} state_t;

	typedef enum logic [2:0] {J_IS0, J_IS1, J_VTX, J_CL0, J_CL1} job_t;

	state_t state_q, state_d;
	job_t   job_q, job_d;
	logic   closing_q, closing_d;
	logic   res_valid_q, res_valid_d;
	op_t    op;

	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		closing_d   = closing_q;
		res_valid_d = res_valid_q && res_stall;
		op          = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (vtx_valid) begin
					op      = OP_CAPTURE;
					state_d = S_START;
				end
			end
			S_START: begin
				if (stat.cnt_zero) begin
					op      = OP_LATCH;
					state_d = S_CLASS;
				end else if (stat.cnt_lt_max) begin
					state_d = S_CLASS;
				end else begin
					op      = OP_SAT;
					state_d = S_CHKLAST;
				end
			end
			S_CLASS: begin
				op      = OP_CLASS;
				state_d = S_BRANCH;
			end
			S_BRANCH: begin
				if (!stat.cnt_zero && stat.cside_ne) begin
					op        = OP_TGT_CUR;
					closing_d = 1'b0;
					state_d   = S_E1;
				end else begin
					job_d   = J_VTX;
					state_d = S_PSEL;
				end
			end
			S_E1: begin op = OP_EMUL;    state_d = S_E2; end
			S_E2: begin op = OP_EDIFF;   state_d = S_E3; end
			S_E3: begin op = OP_ENORM;   state_d = S_BX; end
			S_BX: begin op = OP_BMUL_X;  state_d = S_DX; end
			S_DX: begin op = OP_BDIV_X;  state_d = S_WX; end
			S_WX: begin
				if (!stat.div_busy) begin
					op      = OP_ISX;
					state_d = S_BY;
				end
			end
			S_BY: begin op = OP_BMUL_Y;  state_d = S_DY; end
			S_DY: begin op = OP_BDIV_Y;  state_d = S_WY; end
			S_WY: begin
				if (!stat.div_busy) begin
					op      = OP_ISY;
					job_d   = J_IS0;
					state_d = S_PSEL;
				end
			end
			S_PSEL: begin
				unique case (job_q)
					J_IS0:   op = OP_PT_IS0;
					J_IS1:   op = OP_PT_IS1;
					J_VTX:   op = OP_PT_CUR;
					J_CL0:   op = OP_PT_CL0;
					default: op = OP_PT_CL1;
				endcase
				state_d = S_PMUL;
			end
			S_PMUL: begin op = OP_PMUL; state_d = S_PDIF; end
			S_PDIF: begin op = OP_PDIF; state_d = S_PACC; end
			S_PACC: begin
				op      = OP_PACC;
				state_d = S_PSEL;
				unique case (job_q)
					J_IS0:   job_d = J_IS1;
					J_IS1:   job_d = closing_q ? J_CL0 : J_VTX;
					J_VTX:   state_d = S_ADV;
					J_CL0:   job_d = J_CL1;
					default: state_d = S_ABS;
				endcase
			end
			S_ADV: begin op = OP_ADV; state_d = S_CHKLAST; end
			S_CHKLAST: begin
				if (!stat.last) begin
					state_d = S_IDLE;
				end else if (!stat.cnt_valid) begin
					op      = OP_RES_DEG;
					state_d = S_RES;
				end else if (stat.fside_ne) begin
					op        = OP_TGT_FIRST;
					closing_d = 1'b1;
					state_d   = S_E1;
				end else begin
					closing_d = 1'b1;
					job_d     = J_CL0;
					state_d   = S_PSEL;
				end
			end
			S_ABS: begin op = OP_ABS; state_d = S_TOT; end
			S_TOT: begin op = OP_TOT; state_d = S_NORM; end
			S_NORM: begin
				if (stat.t_big) begin
					op = OP_SHIFT;
				end else if (stat.t_zero) begin
					op      = OP_RES_DEG;
					state_d = S_RES;
				end else begin
					state_d = S_PCTM;
				end
			end
			S_PCTM: begin op = OP_PCTMUL; state_d = S_PCTD; end
			S_PCTD: begin op = OP_PCTDIV; state_d = S_PCTW; end
			S_PCTW: begin
				if (!stat.div_busy) begin
					op      = OP_RES_PCT;
					state_d = S_RES;
				end
			end
			S_RES: begin
				if (!(res_valid_q && res_stall)) begin
					op          = OP_EMIT;
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= J_VTX;
			closing_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			job_q       <= job_d;
			closing_q   <= closing_d;
			res_valid_q <= res_valid_d;
		end
	end

	assign vtx_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign cmd.op    = op;

	`PLSAB_ASSERT_NEXT(a_accept_starts, clk, arst_n, vtx_valid && !vtx_stall,
		state_q == S_START)
	`PLSAB_ASSERT_IMP(a_word_from_res, clk, arst_n, $rose(res_valid_q),
		$past(state_q) == S_RES)
	`PLSAB_ASSERT_IMP(a_wait_busy, clk, arst_n,
		state_q == S_WX || state_q == S_WY || state_q == S_PCTW,
		$past(state_q) != S_IDLE)
endmodule

// ----- design/polygon_line_split_area_balance.sv -----
// channel | direction | handshake              | payload
// vtx     | in        | vtx_valid / vtx_stall  | line_start_*, line_end_*, vertex_*, last_vertex
// res     | out       | res_valid / res_stall  | split_deviation, degenerate
//
// One vertex word at a time; a vertex whose edge crosses the line also makes two passes
// through the shared one-bit-per-cycle divider.
// The last vertex adds a possible closing crossing, up to TOT_W-32 normalizing shifts
// and one more divider pass before the result word is ready.
// Reset (arst_n low) clears the controller, vertex count, side sums and output valid.
// A stalled result word waits in its output register; the next vertex is taken meanwhile.
module polygon_line_split_area_balance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vtx_valid,
	output logic                          vtx_stall,
	input  logic [plsab_pkg::COORD_W-1:0] line_start_x,
	input  logic [plsab_pkg::COORD_W-1:0] line_start_y,
	input  logic [plsab_pkg::COORD_W-1:0] line_end_x,
	input  logic [plsab_pkg::COORD_W-1:0] line_end_y,
	input  logic [plsab_pkg::COORD_W-1:0] vertex_x,
	input  logic [plsab_pkg::COORD_W-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [plsab_pkg::DEV_W-1:0]   split_deviation,
	output logic                          degenerate
);
	import plsab_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	plsab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	plsab_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.line_start_x    (line_start_x),
		.line_start_y    (line_start_y),
		.line_end_x      (line_end_x),
		.line_end_y      (line_end_y),
		.vertex_x        (vertex_x),
		.vertex_y        (vertex_y),
		.last_vertex     (last_vertex),
		.split_deviation (split_deviation),
		.degenerate      (degenerate)
	);
endmodule

// ----- tb/sv/tb_polygon_line_split_area_balance.sv -----
module tb_polygon_line_split_area_balance;
	import plsab_pkg::*;

	typedef struct {
		bit [COORD_W-1:0] lsx, lsy, lex, ley, vx, vy;
		bit last;
	} vertex_word_t;

	typedef struct {
		logic [DEV_W-1:0] dev;
		logic deg;
	} split_result_t;

	class split_scoreboard;
		split_result_t expected_splits[$];
		int lx1, ly1, lx2, ly2, fx, fy, px, py, cnt;
		bit pside;
		bit has [2];
		longint unsigned sfx [2], sfy [2], slx [2], sly [2];
		logic signed [127:0] area2 [2];

		function void clear();
			lx1 = 0; ly1 = 0; lx2 = 0; ly2 = 0; fx = 0; fy = 0; px = 0; py = 0;
			cnt = 0; pside = 0;
			for (int k = 0; k < 2; k++) begin
				has[k] = 0; sfx[k] = 0; sfy[k] = 0; slx[k] = 0; sly[k] = 0; area2[k] = 0;
			end
		endfunction

		function bit above(int vx, int vy);
			longint dx, dy, c;
			dx = lx2 - lx1;
			dy = ly2 - ly1;
			if (dx == 0) return vx < lx1;
			c = dy * (vx - lx1) - (vy - ly1) * dx;
			return (dx > 0) ? (c > 0) : (c < 0);
		endfunction

		function void add_point(int s, longint unsigned x, longint unsigned y);
			if (has[s]) begin
				area2[s] = area2[s] + 128'(slx[s] * y) - 128'(sly[s] * x);
			end else begin
				sfx[s] = x; sfy[s] = y; has[s] = 1;
			end
			slx[s] = x; sly[s] = y;
		endfunction

		function longint unsigned mix(int a, int b, longint num, longint den);
			longint unsigned v;
			v = longint'(a) * (den - num) + longint'(b) * num;
			return ((v << FRAC_BITS) + den / 2) / den;
		endfunction

		function void split_edge(int ax, int ay, int bx, int by);
			longint dx, dy, num, den;
			longint unsigned ix, iy;
			dx = lx2 - lx1;
			dy = ly2 - ly1;
			if (dx == 0) dy = 1;
			num = (lx1 - ax) * dy - (ly1 - ay) * dx;
			den = (bx - ax) * dy - (by - ay) * dx;
			if (den < 0) begin den = -den; num = -num; end
			if (den == 0) begin den = 1; num = 0; end
			if (num < 0) num = 0;
			if (num > den) num = den;
			ix = mix(ax, bx, num, den);
			iy = mix(ay, by, num, den);
			add_point(0, ix, iy);
			add_point(1, ix, iy);
		endfunction

		function void note_vertex(vertex_word_t w);
			bit s;
			logic [127:0] a0, a1, tot, m;
			longint unsigned q;
			split_result_t r;
			if (cnt == 0) begin
				lx1 = w.lsx; ly1 = w.lsy; lx2 = w.lex; ly2 = w.ley;
				fx = w.vx; fy = w.vy;
				s = above(w.vx, w.vy);
				add_point(s, longint'(w.vx) << FRAC_BITS, longint'(w.vy) << FRAC_BITS);
				px = w.vx; py = w.vy; pside = s; cnt = 1;
			end else if (cnt < MAX_VERTICES) begin
				s = above(w.vx, w.vy);
				if (s != pside) split_edge(px, py, w.vx, w.vy);
				add_point(s, longint'(w.vx) << FRAC_BITS, longint'(w.vy) << FRAC_BITS);
				px = w.vx; py = w.vy; pside = s; cnt++;
			end else begin
				cnt = MAX_VERTICES + 1;
			end
			if (!w.last) return;
			r.dev = 0;
			r.deg = 1;
			if (cnt >= 3 && cnt <= MAX_VERTICES) begin
				if (above(fx, fy) != pside) split_edge(px, py, fx, fy);
				for (int k = 0; k < 2; k++)
					if (has[k]) area2[k] = area2[k] + 128'(slx[k] * sfy[k]) - 128'(sly[k] * sfx[k]);
				a0 = (area2[0] < 0) ? -area2[0] : area2[0];
				a1 = (area2[1] < 0) ? -area2[1] : area2[1];
				tot = a0 + a1;
				m = (a0 < a1) ? a0 : a1;
				while (tot >= 128'h1_0000_0000) begin
					tot = tot >> 1;
					m = m >> 1;
				end
				if (tot != 0) begin
					q = (64'd25600 * m[63:0] + tot[63:0] / 2) / tot[63:0];
					if (q > 12800) q = 12800;
					r.dev = DEV_W'(12800 - q);
					r.deg = 0;
				end
			end
			expected_splits.push_back(r);
			clear();
		endfunction

		function string check_split(logic [DEV_W-1:0] dev, logic deg);
			split_result_t e;
			if (expected_splits.size() == 0)
				return $sformatf("unexpected result dev=%0d deg=%0b", dev, deg);
			e = expected_splits.pop_front();
			if (dev !== e.dev || deg !== e.deg)
				return $sformatf("result dev=%0d deg=%0b, want dev=%0d deg=%0b",
					dev, deg, e.dev, e.deg);
			return "";
		endfunction

		function int pending();
			return expected_splits.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic vtx_valid = 0;
	logic vtx_stall;
	logic [COORD_W-1:0] line_start_x = 0, line_start_y = 0, line_end_x = 0, line_end_y = 0;
	logic [COORD_W-1:0] vertex_x = 0, vertex_y = 0;
	logic last_vertex = 0;
	logic res_valid;
	logic res_stall = 0;
	logic [DEV_W-1:0] split_deviation;
	logic degenerate;

	polygon_line_split_area_balance dut (.*);

	split_scoreboard splits = new();
	int errors = 0;
	int send_idle = 28, recv_idle = 70;
	int hold_left = 0;
	bit hold_done = 0, pressure_on = 0;
	int quiet_cycles = 0;
	int words_sent = 0;

	initial forever #6 clk = ~clk;

	task automatic report(string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				msg = splits.check_split(split_deviation, degenerate);
				if (msg != "") report(msg);
			end
			if (pressure_on && !hold_done) begin
				hold_done <= 1;
				hold_left <= 1500;
				res_stall <= 1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(vertex_word_t w);
		while ($urandom_range(99) < send_idle) begin
			vtx_valid <= 0;
			@(posedge clk);
		end
		line_start_x <= w.lsx; line_start_y <= w.lsy;
		line_end_x <= w.lex; line_end_y <= w.ley;
		vertex_x <= w.vx; vertex_y <= w.vy; last_vertex <= w.last;
		vtx_valid <= 1;
		do @(posedge clk); while (vtx_stall);
		splits.note_vertex(w);
		words_sent++;
	endtask

	// polygon with given line; pts holds x,y pairs
	task automatic send_polygon(int l[4], int pts[$]);
		vertex_word_t w;
		int n;
		n = pts.size() / 2;
		for (int i = 0; i < n; i++) begin
			w.lsx = COORD_W'(l[0]); w.lsy = COORD_W'(l[1]);
			w.lex = COORD_W'(l[2]); w.ley = COORD_W'(l[3]);
			if (i > 0) begin
				w.lsx = COORD_W'($urandom); w.lsy = COORD_W'($urandom);
				w.lex = COORD_W'($urandom); w.ley = COORD_W'($urandom);
			end
			w.vx = COORD_W'(pts[2*i]); w.vy = COORD_W'(pts[2*i+1]);
			w.last = (i == n - 1);
			send_word(w);
		end
	endtask

	task automatic random_polygon();
		int l[4];
		int pts[$];
		int n, r, lo, hi, sel;
		r = $urandom_range(99);
		n = (r < 5) ? $urandom_range(2, 1) : (r < 10) ? $urandom_range(20, 17)
			: $urandom_range(MAX_VERTICES, 3);
		lo = 0; hi = 255;
		if ($urandom_range(3) == 0) begin lo = $urandom_range(200); hi = lo + 50; end
		for (int k = 0; k < 4; k++) l[k] = $urandom_range(hi, lo);
		sel = $urandom_range(19);
		if (sel == 0) l[2] = l[0];
		else if (sel == 1) begin l[2] = l[0]; l[3] = l[1]; end
		for (int i = 0; i < n; i++) begin
			if (sel == 2) begin
				pts.push_back(lo + i); pts.push_back(lo + i);
			end else if (sel == 3 && i > 0) begin
				pts.push_back(l[0]); pts.push_back(l[1]);
			end else begin
				pts.push_back($urandom_range(hi, lo)); pts.push_back($urandom_range(hi, lo));
			end
		end
		send_polygon(l, pts);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_polygon('{0, 128, 255, 128}, '{0, 0, 255, 0, 255, 255, 0, 255});
		send_polygon('{100, 0, 100, 255}, '{50, 10, 200, 10, 150, 250});
		send_polygon('{60, 60, 60, 60}, '{10, 10, 120, 20, 30, 200});
		send_polygon('{0, 0, 255, 255}, '{10, 20, 30, 40});
		send_polygon('{0, 0, 255, 255}, '{255, 0});
		send_polygon('{0, 255, 255, 0}, '{5, 5, 100, 100, 200, 200});
		send_polygon('{255, 255, 0, 0}, '{0, 0, 255, 0, 255, 255, 0, 255});
		while (words_sent < 2020) begin
			if (words_sent > 1350) begin
				send_idle = 0; recv_idle = 0; pressure_on = 1;
			end else if (words_sent > 700) begin
				send_idle = 70; recv_idle = 28;
			end
			random_polygon();
		end
		vtx_valid <= 0;
		while (splits.pending() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (splits.pending() > 0) report("results still expected at end");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
